@@ src/utf8sf_pkg.sv @@
// utf8sf_pkg: shared types and constants for the UTF-8 structure filter
`timescale 1ns / 1ps
package utf8sf_pkg;

  // replacement character
  localparam logic [7:0] QMARK = 8'h3F;

  // most words one input word can produce
  localparam int MAX_RESULTS = 4;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
  localparam int RES_IW      = $clog2(MAX_RESULTS);

  // output queue geometry
  localparam int Q_DEPTH     = 8;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);
  localparam int STALL_LEVEL = Q_DEPTH - MAX_RESULTS;

  // words produced by one input word, in order; last flags the final one
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [RES_CW-1:0]           count;
    logic                        last;
  } utf8sf_result_t;

endpackage

@@ src/utf8_structure_filter_top.sv @@
// utf8_structure_filter_top: UTF-8 structure filter, byte in, byte out
`timescale 1ns / 1ps
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  ------------------
// in       sink       in_valid / in_stall    in_byte, in_last
// out      source     out_valid / out_stall  out_byte, out_last
//
// One input word is taken per cycle while in_stall is low. Its results
// (zero to four words) go into an eight-entry queue at the same edge and
// appear on out from the next cycle, one word per cycle unless out_stall.
// in_stall rises only when the queue has fewer than four free entries; it
// comes from the registered fill count alone, never from out_stall directly.
// Reset (rst, synchronous) empties the queue and drops any pending sequence.
//
module utf8_structure_filter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic                       accept;
  logic                       full;
  utf8sf_pkg::utf8sf_result_t result;

  // word taken when valid and the queue has room for a full burst
  assign in_stall = full;
  assign accept   = in_valid && !full;

  // sequence tracking: lead, held continuations, counts
  utf8sf_filter u_filter (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .result  (result)
  );

  // result queue parts the two channels
  utf8sf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept),
    .result    (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ src/utf8sf_filter.sv @@
// utf8sf_filter: sequence tracking state and per-word result generation
`timescale 1ns / 1ps
module utf8sf_filter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                in_byte,
  input  logic                      in_last,
  output utf8sf_pkg::utf8sf_result_t result
);

  logic [7:0]      held_lead;
  logic [1:0][7:0] held_cont;
  logic [1:0]      needed_count;
  logic [1:0]      held_count;

  logic [7:0]      held_lead_next;
  logic [1:0][7:0] held_cont_next;
  logic [1:0]      needed_count_next;
  logic [1:0]      held_count_next;

  logic            is_cont;

  assign is_cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    logic [utf8sf_pkg::RES_CW-1:0] n;
    logic [utf8sf_pkg::MAX_RESULTS-1:0][7:0] bytes;
    held_lead_next    = held_lead;
    held_cont_next    = held_cont;
    needed_count_next = needed_count;
    held_count_next   = held_count;
    bytes             = '0;
    n                 = '0;

    if (needed_count != 2'd0 && is_cont) begin
      if (needed_count == 2'd1) begin
        // sequence complete: release it unchanged
        bytes[0] = held_lead;
        n        = utf8sf_pkg::RES_CW'(1);
        for (int i = 0; i < 2; i++) begin
          if (2'(i) < held_count) begin
            bytes[n[utf8sf_pkg::RES_IW-1:0]] = held_cont[i];
            n = n + utf8sf_pkg::RES_CW'(1);
          end
        end
        bytes[n[utf8sf_pkg::RES_IW-1:0]] = in_byte;
        n = n + utf8sf_pkg::RES_CW'(1);
        held_lead_next    = '0;
        needed_count_next = 2'd0;
        held_count_next   = 2'd0;
      end else begin
        held_cont_next[held_count[0]] = in_byte;
        held_count_next   = held_count + 2'd1;
        needed_count_next = needed_count - 2'd1;
      end
    end else begin
      // broken sequence: lead and held continuations become '?'
      if (needed_count != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) <= held_count) begin
            bytes[n[utf8sf_pkg::RES_IW-1:0]] = utf8sf_pkg::QMARK;
            n = n + utf8sf_pkg::RES_CW'(1);
          end
        end
        held_lead_next    = '0;
        needed_count_next = 2'd0;
        held_count_next   = 2'd0;
      end
      // examine the word as a fresh lead
      if (!in_byte[7]) begin
        bytes[n[utf8sf_pkg::RES_IW-1:0]] = in_byte;
        n = n + utf8sf_pkg::RES_CW'(1);
      end else if (in_byte[7:5] == 3'b110) begin
        held_lead_next    = in_byte;
        needed_count_next = 2'd1;
        held_count_next   = 2'd0;
      end else if (in_byte[7:4] == 4'b1110) begin
        held_lead_next    = in_byte;
        needed_count_next = 2'd2;
        held_count_next   = 2'd0;
      end else if (in_byte[7:3] == 5'b11110) begin
        held_lead_next    = in_byte;
        needed_count_next = 2'd3;
        held_count_next   = 2'd0;
      end else begin
        bytes[n[utf8sf_pkg::RES_IW-1:0]] = utf8sf_pkg::QMARK;
        n = n + utf8sf_pkg::RES_CW'(1);
      end
    end

    // end of string: flush whatever is still pending
    if (in_last) begin
      if (needed_count_next != 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) <= held_count_next) begin
            bytes[n[utf8sf_pkg::RES_IW-1:0]] = utf8sf_pkg::QMARK;
            n = n + utf8sf_pkg::RES_CW'(1);
          end
        end
      end
      held_lead_next    = '0;
      needed_count_next = 2'd0;
      held_count_next   = 2'd0;
    end

    result.bytes = bytes;
    result.count = n;
    result.last  = in_last && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead    <= '0;
      needed_count <= 2'd0;
      held_count   <= 2'd0;
    end else if (accept) begin
      held_lead    <= held_lead_next;
      needed_count <= needed_count_next;
      held_count   <= held_count_next;
    end
  end

  // continuation store: only read after being written
  always_ff @(posedge clk) begin
    if (accept) begin
      held_cont <= held_cont_next;
    end
  end

`ifndef ASSERT_OFF
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    needed_count == 2'd0 |-> held_count == 2'd0)
    else $error("continuations held with no sequence pending");

  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    needed_count != 2'd0 |-> ({1'b0, held_count} + {1'b0, needed_count}) <= 3'd3)
    else $error("pending sequence longer than four words");

  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> needed_count == 2'd0)
    else $error("sequence still pending after end of string");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |-> result.count != '0 && result.last)
    else $error("end of string produced no final word");
`endif

endmodule

@@ src/utf8sf_queue.sv @@
// utf8sf_queue: result queue, up to four words written per cycle, one read
`timescale 1ns / 1ps
module utf8sf_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  utf8sf_pkg::utf8sf_result_t result,
  output logic                       full,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_byte,
  output logic                       out_last
);

  logic [7:0] q_byte [utf8sf_pkg::Q_DEPTH];
  logic       q_last [utf8sf_pkg::Q_DEPTH];

  logic [utf8sf_pkg::Q_AW-1:0] wr_ptr;
  logic [utf8sf_pkg::Q_AW-1:0] rd_ptr;
  logic [utf8sf_pkg::Q_CW-1:0] count;
  logic [utf8sf_pkg::Q_CW-1:0] count_next;
  logic [utf8sf_pkg::Q_CW-1:0] wr_n;
  logic                        rd;

  assign wr_n      = wr_en ? utf8sf_pkg::Q_CW'(result.count) : '0;
  assign rd        = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_byte  = q_byte[rd_ptr];
  assign out_last  = q_last[rd_ptr];
  // room for a full burst must exist before a word is taken
  assign full      = (count > utf8sf_pkg::Q_CW'(utf8sf_pkg::STALL_LEVEL));

  always_comb begin
    count_next = count + wr_n - (rd ? utf8sf_pkg::Q_CW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < utf8sf_pkg::MAX_RESULTS; k++) begin
      if (wr_en && utf8sf_pkg::RES_CW'(k) < result.count) begin
        q_byte[wr_ptr + utf8sf_pkg::Q_AW'(k)] <= result.bytes[k];
        q_last[wr_ptr + utf8sf_pkg::Q_AW'(k)] <=
          result.last && (utf8sf_pkg::RES_CW'(k + 1) == result.count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr_n[utf8sf_pkg::Q_AW-1:0];
      if (rd) begin
        rd_ptr <= rd_ptr + utf8sf_pkg::Q_AW'(1);
      end
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= utf8sf_pkg::Q_CW'(utf8sf_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  a_burst_fits: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count + wr_n) <= utf8sf_pkg::Q_CW'(utf8sf_pkg::Q_DEPTH))
    else $error("burst written without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (rd_ptr + count[utf8sf_pkg::Q_AW-1:0]) == wr_ptr)
    else $error("queue pointers and fill count disagree");
`endif

endmodule

@@ sim/utf8sf_checker.sv @@
// utf8sf_checker: predicts and checks the filtered byte stream of the UTF-8 structure filter
`timescale 1ns / 1ps
module utf8sf_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         words_owed
);

  localparam logic [7:0] TOP2_MASK = 8'hC0;
  localparam logic [7:0] TOP3_MASK = 8'hE0;
  localparam logic [7:0] TOP4_MASK = 8'hF0;
  localparam logic [7:0] TOP5_MASK = 8'hF8;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;
  localparam logic [7:0] LEAD4_TAG = 8'hF0;
  localparam int         REPORT_MAX = 10;

  typedef struct {
    logic [7:0] val;
    logic       fin;
  } filt_word_t;

  filt_word_t filt_expected[$];
  logic [7:0] step_words[$];

  // pending sequence
  logic [7:0] lead_byte;
  logic [7:0] cont_bytes [0:1];
  logic [1:0] missing_cnt;
  logic [1:0] held_cnt;

  // append one word to this step's results
  task automatic add_step_word(input logic [7:0] b);
    step_words = {step_words, b};
  endtask

  // broken or cut-off sequence: lead and held continuations all turn to '?'
  task automatic flush_pending();
    if (missing_cnt != 2'd0) begin
      add_step_word(utf8sf_pkg::QMARK);
      for (int i = 0; i < held_cnt; i++) add_step_word(utf8sf_pkg::QMARK);
      lead_byte   = 8'h00;
      missing_cnt = 2'd0;
      held_cnt    = 2'd0;
    end
  endtask

  task automatic start_fresh(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_step_word(b);
    end else if ((b & TOP3_MASK) == LEAD2_TAG) begin
      lead_byte = b; missing_cnt = 2'd1; held_cnt = 2'd0;
    end else if ((b & TOP4_MASK) == LEAD3_TAG) begin
      lead_byte = b; missing_cnt = 2'd2; held_cnt = 2'd0;
    end else if ((b & TOP5_MASK) == LEAD4_TAG) begin
      lead_byte = b; missing_cnt = 2'd3; held_cnt = 2'd0;
    end else begin
      add_step_word(utf8sf_pkg::QMARK);
    end
  endtask

  task automatic filter_word(input logic [7:0] b, input logic fin);
    filt_word_t w;
    step_words.delete();
    if (missing_cnt != 2'd0) begin
      if ((b & TOP2_MASK) == CONT_TAG) begin
        if (missing_cnt == 2'd1) begin
          add_step_word(lead_byte);
          for (int i = 0; i < held_cnt; i++) add_step_word(cont_bytes[i]);
          add_step_word(b);
          lead_byte   = 8'h00;
          missing_cnt = 2'd0;
          held_cnt    = 2'd0;
        end else begin
          cont_bytes[held_cnt[0]] = b;
          held_cnt    = held_cnt + 2'd1;
          missing_cnt = missing_cnt - 2'd1;
        end
      end else begin
        flush_pending();
        start_fresh(b);
      end
    end else begin
      start_fresh(b);
    end
    if (fin) flush_pending();
    for (int i = 0; i < step_words.size(); i++) begin
      w.val = step_words[i];
      w.fin = fin && (i == step_words.size() - 1);
      filt_expected = {filt_expected, w};
    end
  endtask

  always @(posedge clk) begin
    filt_word_t w;
    if (rst) begin
      filt_expected.delete();
      lead_byte     = 8'h00;
      cont_bytes[0] = 8'h00;
      cont_bytes[1] = 8'h00;
      missing_cnt   = 2'd0;
      held_cnt      = 2'd0;
      fail_count   <= 0;
    end else begin
      // results never leave in the cycle their input arrives, so pop first
      if (out_valid && !out_stall) begin
        if (filt_expected.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: unexpected word %h last %b", $realtime, out_byte, out_last);
          fail_count <= fail_count + 1;
        end else begin
          w = filt_expected.pop_front();
          if (out_byte !== w.val || out_last !== w.fin) begin
            if (fail_count < REPORT_MAX)
              $display("%0t: mismatch: expected byte %h last %b, got byte %h last %b",
                       $realtime, w.val, w.fin, out_byte, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) filter_word(in_byte, in_last);
    end
    words_owed <= filt_expected.size();
  end

endmodule

@@ sim/tb.sv @@
// tb: stimulus, idling phases, watchdog and verdict for the UTF-8 structure filter
`timescale 1ns / 1ps
module tb;

  // sender and receiver hold-off in each phase, percent of cycles
  localparam int PHASES         = 4;
  localparam int WORDS_PER_PHASE = 108;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 5000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int fail_count;
  int words_owed;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  int tx_plan [0:PHASES-1] = '{0, 77, 0, 20};
  int rx_plan [0:PHASES-1] = '{0, 0, 77, 20};

  always #1 clk = ~clk;

  utf8_structure_filter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  utf8sf_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  // receiver back-pressure, redrawn every cycle at the current rate
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < rx_stall_pct);
  end

  // watchdog: any cycle without a handshake on either side counts
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with a random hold-off first. Called at a rising edge;
  // returns at the edge where the word is taken. in_stall is looked at on
  // the falling edge, where it is settled, so no race with the block's update.
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // One random token: mostly whole sequences with random payload bits,
  // the rest cut-off sequences, stray continuations and arbitrary bytes.
  task automatic send_token();
    logic [7:0] seq [0:3];
    int kind;
    int seq_len;
    int full_len;
    kind     = $urandom_range(0, 9);
    full_len = 1;
    case (kind)
      0, 1, 2: seq[0] = 8'($urandom_range(0, 127));
      3, 4, 5, 6, 7: begin
        full_len = (kind == 5) ? 3 : (kind == 6) ? 4 :
                   (kind == 7) ? $urandom_range(2, 4) : 2;
        case (full_len)
          2:       seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
          3:       seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
          default: seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        for (int i = 1; i < 4; i++) seq[i] = 8'h80 | 8'($urandom_range(0, 63));
      end
      8:       seq[0] = 8'h80 | 8'($urandom_range(0, 63));
      default: seq[0] = 8'($urandom_range(0, 255));
    endcase
    // cut-off: keep the lead and only some of its continuations
    seq_len = (kind == 7) ? $urandom_range(1, full_len - 1) : full_len;
    for (int i = 0; i < seq_len; i++)
      send_word(seq[i], $urandom_range(0, 15) == 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: ASCII extremes, stray continuation as end of string,
    // bytes above the lead range, each sequence length whole
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'hF8, 1'b0);
    send_word(8'hC3, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    // four-byte sequence finished by the end mark
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b0);
    send_word(8'h80, 1'b1);
    // broken by ASCII with one continuation held
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'h41, 1'b0);
    // broken by a new lead, which is then cut off by the end mark
    send_word(8'hC3, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b1);
    // two continuations held, broken by a lead that carries the end mark
    send_word(8'hF4, 1'b0);
    send_word(8'h8F, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hC0, 1'b1);
    send_word(8'h41, 1'b1);

    // random tokens over the idling phases
    for (int p = 0; p < PHASES; p++) begin
      tx_idle_pct  = tx_plan[p];
      rx_stall_pct = rx_plan[p];
      while (words_sent < WORDS_PER_PHASE * (p + 1)) send_token();
    end
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray words
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/utf8sf_pkg.sv
src/utf8sf_filter.sv
src/utf8sf_queue.sv
src/utf8_structure_filter_top.sv
sim/utf8sf_checker.sv
sim/tb.sv
